// File: rtl/core/mks_pkg.sv
// Shared types, constants and decode functions for the matrix keypad scanner.
package mks_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DEBOUNCE_WIDTH  = 16;
  localparam int COL_WIDTH       = 4;
  localparam int ROW_WIDTH       = 4;
  localparam int DIGIT_WIDTH     = 4;

  localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [COL_WIDTH-1:0]      COLS_IDLE      = 4'hf;
  localparam logic [COL_WIDTH-1:0]      COLS_C0        = 4'he;
  localparam logic [COL_WIDTH-1:0]      COLS_C1        = 4'hd;
  localparam logic [COL_WIDTH-1:0]      COLS_C2        = 4'hb;
  localparam logic [ROW_WIDTH-1:0]      ROWS_ALL       = 4'h0;

  typedef enum logic [3:0] {
    PH_RELEASE = 4'b0001,
    PH_PRESS   = 4'b0010,
    PH_CONFIRM = 4'b0100,
    PH_SCAN    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [ROW_WIDTH-1:0]   row_drive;
    logic                   key_valid;
    logic [DIGIT_WIDTH-1:0] key_value;
  } result_t;

  // A sample with one low column names that column; anything else is column 3.
  function automatic logic [1:0] col_index(input logic [COL_WIDTH-1:0] cols);
    logic [1:0] idx;
    case (cols)
      COLS_C0: idx = 2'd0;
      COLS_C1: idx = 2'd1;
      COLS_C2: idx = 2'd2;
      default: idx = 2'd3;
    endcase
    return idx;
  endfunction

  // Fixed key table, indexed by row and column.
  function automatic logic [DIGIT_WIDTH-1:0] key_digit(input logic [3:0] key);
    logic [DIGIT_WIDTH-1:0] d;
    case (key)
      4'd0:    d = 4'd6;
      4'd1:    d = 4'd5;
      4'd2:    d = 4'd4;
      4'd3:    d = 4'd3;
      4'd4:    d = 4'd2;
      4'd5:    d = 4'd1;
      4'd6:    d = 4'd0;
      4'd7:    d = 4'd9;
      4'd8:    d = 4'd8;
      4'd9:    d = 4'd7;
      4'd10:   d = 4'd6;
      4'd11:   d = 4'd5;
      4'd12:   d = 4'd4;
      4'd13:   d = 4'd3;
      4'd14:   d = 4'd2;
      default: d = 4'd1;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/core/mks_if.sv
// Handshake interfaces for the column samples, the key results and configuration.
interface mks_col_if;
  import mks_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COL_WIDTH-1:0] col_sample;
  modport source (output valid, output col_sample, input ready);
  modport sink   (input valid, input col_sample, output ready);
endinterface

interface mks_key_if;
  import mks_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ROW_WIDTH-1:0]   row_drive;
  logic                   key_valid;
  logic [DIGIT_WIDTH-1:0] key_value;
  modport source (output valid, output row_drive, output key_valid, output key_value,
                  input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_value,
                  output ready);
endinterface

interface mks_cfg_if;
  import mks_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
  modport source (output valid, output debounce_ticks, input ready);
  modport sink   (input valid, input debounce_ticks, output ready);
endinterface

// File: rtl/core/mks_step.sv
// Next-state and result logic for one tick of the keypad scanner.
module mks_step #(
  parameter int COUNT_WIDTH = mks_pkg::COUNT_WIDTH_DEF
) (
  input  mks_pkg::phase_t                         phase,
  input  logic [COUNT_WIDTH-1:0]                  tick_count,
  input  logic [1:0]                              row_index,
  input  logic [mks_pkg::COL_WIDTH-1:0]           col_sample,
  input  logic [mks_pkg::DEBOUNCE_WIDTH-1:0]      debounce_ticks,
  output mks_pkg::phase_t                         phase_next,
  output logic [COUNT_WIDTH-1:0]                  tick_count_next,
  output logic [1:0]                              row_index_next,
  output mks_pkg::result_t                        result
);
  import mks_pkg::*;

  localparam int CmpW = ((COUNT_WIDTH > DEBOUNCE_WIDTH) ? COUNT_WIDTH : DEBOUNCE_WIDTH) + 1;

  logic [CmpW-1:0]        cnt_inc;
  logic [CmpW-1:0]        cnt_max;
  logic                   interval_done;
  logic [COUNT_WIDTH-1:0] tick_after;
  logic                   cols_idle;

  // The interval ends when the count reaches the debounce setting or the
  // counter's own limit, whichever comes first.
  assign cnt_inc       = CmpW'(tick_count) + CmpW'(1);
  assign cnt_max       = CmpW'({COUNT_WIDTH{1'b1}});
  assign interval_done = (cnt_inc >= CmpW'(debounce_ticks)) || (cnt_inc >= cnt_max);
  assign tick_after    = interval_done ? '0 : cnt_inc[COUNT_WIDTH-1:0];
  assign cols_idle     = (col_sample == COLS_IDLE);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    row_index_next   = row_index;
    result.row_drive = ROWS_ALL;
    result.key_valid = 1'b0;
    result.key_value = '0;
    case (phase)
      PH_PRESS: begin
        tick_count_next = tick_after;
        if (interval_done && !cols_idle) begin
          phase_next = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        tick_count_next = tick_after;
        if (interval_done) begin
          if (!cols_idle) begin
            phase_next     = PH_SCAN;
            row_index_next = 2'd0;
          end else begin
            phase_next = PH_PRESS;
          end
        end
      end
      PH_SCAN: begin
        result.row_drive = ~(ROW_WIDTH'(1) << row_index);
        if (!cols_idle || (row_index == 2'd3)) begin
          result.key_valid = 1'b1;
          result.key_value = key_digit({row_index, col_index(col_sample)});
          phase_next       = PH_RELEASE;
          row_index_next   = 2'd0;
          tick_count_next  = '0;
        end else begin
          row_index_next = row_index + 2'd1;
        end
      end
      default: begin
        if (cols_idle) begin
          phase_next      = PH_PRESS;
          tick_count_next = '0;
        end else begin
          phase_next = PH_RELEASE;
        end
      end
    endcase
  end

endmodule

// File: rtl/core/matrix_keypad_scanner.sv
// Top level of the debounced 4x4 matrix keypad scanner.
//
// The block takes one beat per keypad tick on the col channel, carrying the
// four active-low column levels read during that tick. For every input beat
// it returns exactly one beat on the key channel: the row levels held during
// that tick, and, on the tick a key is decoded, key_valid with the digit.
// The cfg channel writes the debounce interval in ticks; it is always ready
// and is meant to be written only while no beats are in flight.
//
// An accepted col beat is held in the input register, then passes through
// the scan state machine into the result register, which drives its key beat.
// Throughput is one beat per cycle while the receiver is ready; the only loop
// is the scanner state (phase, tick counter, row index), computed combinationally.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and col.ready drops until the result is taken.
// Reset clears both pipeline registers, sets the debounce interval to 20 and
// puts the scanner in the phase that waits for all keys to be released.
module matrix_keypad_scanner #(
  parameter int COUNT_WIDTH = mks_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  mks_col_if.sink   col,
  mks_key_if.source key,
  mks_cfg_if.sink   cfg
);
  import mks_pkg::*;

  // Configuration register.
  logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;

  // Input register.
  logic                 in_valid;
  logic [COL_WIDTH-1:0] in_cols;

  // Scanner state.
  phase_t                 phase;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [1:0]             row_index;
  phase_t                 phase_next;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic [1:0]             row_index_next;

  // Result register.
  logic    out_valid;
  result_t out_data;
  result_t step_result;

  logic advance;

  // The held sample moves into the result register whenever that register
  // is empty or its beat is being taken this cycle.
  assign advance   = in_valid && (!out_valid || key.ready);
  assign col.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  assign key.valid     = out_valid;
  assign key.row_drive = out_data.row_drive;
  assign key.key_valid = out_data.key_valid;
  assign key.key_value = out_data.key_value;

  mks_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .phase           (phase),
    .tick_count      (tick_count),
    .row_index       (row_index),
    .col_sample      (in_cols),
    .debounce_ticks  (debounce_ticks),
    .phase_next      (phase_next),
    .tick_count_next (tick_count_next),
    .row_index_next  (row_index_next),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg.valid) begin
      debounce_ticks <= cfg.debounce_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (col.ready) begin
      in_valid <= col.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (col.valid && col.ready) begin
      in_cols <= col.col_sample;
    end
  end

  // The scanner state steps once per sample, as that sample's result is made.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RELEASE;
      tick_count <= '0;
      row_index  <= 2'd0;
    end else if (advance) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      row_index  <= row_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (key.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule
